// ----- src/atom_record_half_encoder_unit_assert.svh -----
// Assertion macros for the atom record half encoder
`ifndef ATOM_RECORD_HALF_ENCODER_UNIT_ASSERT_SVH
`define ATOM_RECORD_HALF_ENCODER_UNIT_ASSERT_SVH

// implication checked every clock outside reset
`define AREH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the next cycle
`define AREH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/areh_pkg.sv -----
// Package: widths, types and half conversion constants for the atom record encoder
`default_nettype none
package areh_pkg;
   localparam int unsigned NUM_LANES  = 9;
   localparam int unsigned SGL_W      = 32;
   localparam int unsigned HALF_W     = 16;
   localparam int unsigned FLAG_W     = 16;
   localparam int unsigned REQ_DATA_W = NUM_LANES * SGL_W + FLAG_W;
   localparam int unsigned RSP_DATA_W = NUM_LANES * HALF_W + FLAG_W;

   localparam logic [7:0]  EXP_OVF    = 8'd143;
   localparam logic [7:0]  EXP_NORM   = 8'd113;
   localparam logic [7:0]  EXP_SUB    = 8'd102;
   localparam logic [7:0]  EXP_MAX    = 8'd255;
   localparam logic [15:0] HALF_QNAN  = 16'h7E00;
   localparam logic [15:0] HALF_INF   = 16'h7C00;
   localparam logic [23:0] RND_HALF   = 24'h001000;

   typedef logic [HALF_W-1:0] half_type;
endpackage
`default_nettype wire

// ----- src/areh_lane.sv -----
// One conversion lane: single-precision bit pattern to half, registered
`default_nettype none
module areh_lane import areh_pkg::*; (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [SGL_W-1:0]  value,
   output      half_type          half
);
   logic [7:0]  exp_v;
   logic [22:0] man_v;
   logic        sgn_v;
   logic [23:0] sig_v;
   logic [23:0] shr_v;
   logic [24:0] sum_v;
   logic [4:0]  amt_v;
   logic [14:0] mag_v;
   half_type    half_in, half_ff;

   always_comb begin
      sgn_v = value[31];
      exp_v = value[30:23];
      man_v = value[22:0];
      sig_v = {1'b1, man_v};
      amt_v = 5'(EXP_NORM - exp_v);
      shr_v = sig_v >> amt_v;
      sum_v = 25'(man_v) + 25'(RND_HALF);
      mag_v = '0;
      if (exp_v >= EXP_OVF) begin
         if (exp_v == EXP_MAX && man_v != '0) mag_v = HALF_QNAN[14:0];
         else mag_v = HALF_INF[14:0];
      end else if (exp_v < EXP_NORM) begin
         if (exp_v < EXP_SUB) mag_v = '0;
         else mag_v = 15'((25'(shr_v) + 25'(RND_HALF)) >> 13);
      end else begin
         mag_v = 15'({5'(exp_v - 8'd112), 10'd0}) + 15'(sum_v >> 13);
      end
      half_in = {sgn_v, mag_v};
   end

   always_ff @(posedge clock) begin
      if (load) half_ff <= half_in;
   end
   assign half = half_ff;
endmodule
`default_nettype wire

// ----- src/atom_record_half_encoder_unit.sv -----
// Top level: nine parallel half lanes merged into one result item
//   channel | dir | tdata fields (low bit first)
//   req     | in  | x,y,sxx,sxy,syy,alpha,luma,co,cg (32 b each), flag_bits (16 b)
//   rsp     | out | x..cg halves (16 b each), flag_word (16 b)
// One item per cycle unless stalled; lane registers give each result in the cycle after acceptance.
// The result register holds while rsp_tready is low; req_tready follows it
// so a new item enters whenever the register is empty or being drained.
// Synchronous reset clears only the result valid flag.
`default_nettype none
`include "atom_record_half_encoder_unit_assert.svh"
module atom_record_half_encoder_unit import areh_pkg::*; #(
   parameter int unsigned LANES = NUM_LANES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [LANES*SGL_W+FLAG_W-1:0] req_tdata,  // x,y,sxx,sxy,syy,alpha,luma,co,cg,flag_bits
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [LANES*HALF_W+FLAG_W-1:0] rsp_tdata  // x..cg halves, flag_word
);
   logic              valid_ff, valid_in;
   logic [FLAG_W-1:0] flag_ff;
   logic              load;

   assign req_tready = !valid_ff || rsp_tready;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end
   always_ff @(posedge clock) begin
      if (load) flag_ff <= req_tdata[LANES*SGL_W +: FLAG_W];
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      areh_lane u_lane (
         .clock (clock),
         .load  (load),
         .value (req_tdata[i*SGL_W +: SGL_W]),
         .half  (rsp_tdata[i*HALF_W +: HALF_W])
      );
   end
   assign rsp_tdata[LANES*HALF_W +: FLAG_W] = flag_ff;
   assign rsp_tvalid = valid_ff;

   `AREH_ASSERT_NEXT(a_load_valid, clock, reset, load, rsp_tvalid, "accepted item not shown")
   `AREH_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready && !load, $stable(rsp_tdata), "result changed while stalled")
   `AREH_ASSERT_IMP(a_ready, clock, reset, !rsp_tvalid, req_tready, "not ready while empty")
endmodule
`default_nettype wire
